// ----- design/rpn_stack_calculator_defines.svh -----
// Assertion macros shared by the stack calculator RTL.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge except while reset is high.
`define RPN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define RPN_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define RPN_ASSERT(label, prop, msg)
`define RPN_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- design/rpn_pkg.sv -----
// Types, codes and helper functions for the stack calculator.
package rpn_pkg;

   // Command codes carried on req_cmd.
   localparam logic [3:0] CMD_PUSH   = 4'd0;
   localparam logic [3:0] CMD_ADD    = 4'd1;
   localparam logic [3:0] CMD_SUB    = 4'd2;
   localparam logic [3:0] CMD_MUL    = 4'd3;
   localparam logic [3:0] CMD_DIV    = 4'd4;
   localparam logic [3:0] CMD_MOD    = 4'd5;
   localparam logic [3:0] CMD_PEEK   = 4'd6;
   localparam logic [3:0] CMD_DUP    = 4'd7;
   localparam logic [3:0] CMD_SWAP   = 4'd8;
   localparam logic [3:0] CMD_CLEAR  = 4'd9;
   localparam logic [3:0] CMD_RESULT = 4'd10;

   // Status codes carried on rsp_status.
   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_EMPTY   = 3'd1;
   localparam logic [2:0] STAT_FULL    = 3'd2;
   localparam logic [2:0] STAT_ZDIV    = 3'd3;
   localparam logic [2:0] STAT_SWAP    = 3'd4;
   localparam logic [2:0] STAT_UNKNOWN = 3'd5;

   // Saturation limits of a signed 32-bit word.
   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   // Width of one stack word.
   localparam int unsigned WORD_W = 32;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV,
      ALU_MOD
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef enum logic [1:0] {
      A_IDLE,
      A_RUN,
      A_FIN
   } alu_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ_B,
      S_READ_A,
      S_SWAP_WR,
      S_EXEC,
      S_ALU_WAIT,
      S_DONE
   } ctl_state_type;

   // Turns a magnitude and a sign into a saturated signed 32-bit word.
   function automatic logic [31:0] from_mag(input logic [63:0] mag, input logic neg);
      logic ovf;
      ovf = |mag[63:31];
      if (neg) begin
         from_mag = ovf ? SAT_MIN : (32'd0 - mag[31:0]);
      end else begin
         from_mag = ovf ? SAT_MAX : mag[31:0];
      end
   endfunction

endpackage

// ----- design/rpn_stack_mem.sv -----
// Stack storage: one write port and one registered read port.
module rpn_stack_mem #(
   parameter int unsigned DEPTH = 128,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // Write and read share the clock; read data is registered and shows in the next cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rpn_alu.sv -----
// Serial arithmetic unit: bit-serial add and subtract, shift-add multiply,
// restoring divide and remainder, each with saturation at the end.
module rpn_alu #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rpn_pkg::alu_ctl_type ctl,
   input  logic [31:0]         opa,
   input  logic [31:0]         opb,
   output logic                done,
   output logic [31:0]         result
);

   localparam int unsigned DW   = 32 + FRAC_BITS;
   localparam int unsigned CNTW = $clog2(DW + 1);

   rpn_pkg::alu_state_type state_ff, state_in;
   rpn_pkg::alu_op_type    op_ff, op_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [31:0]     a_sr_ff, a_sr_in;
   logic [31:0]     b_sr_ff, b_sr_in;
   logic [31:0]     hi_ff, hi_in;
   logic            carry_ff, carry_in;
   logic            sign_a_ff, sign_a_in;
   logic            sign_b_ff, sign_b_in;
   logic            neg_ff, neg_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [31:0]     rem_ff, rem_in;

   logic [31:0] mag_a, mag_b;
   logic        sum_bit;
   logic [32:0] mul_sum;
   logic [32:0] trial;
   logic        q_bit;
   logic [63:0] prod, mul_mag;
   logic        add_ovf;

   // Operand magnitudes for the unsigned multiply and divide.
   assign mag_a = opa[31] ? (32'd0 - opa) : opa;
   assign mag_b = opb[31] ? (32'd0 - opb) : opb;

   // One bit of the serial adder, least significant first.
   assign sum_bit = a_sr_ff[0] ^ b_sr_ff[0] ^ carry_ff;

   // One step of shift-add multiply.
   assign mul_sum = {1'b0, hi_ff} + (b_sr_ff[0] ? {1'b0, a_sr_ff} : 33'd0);

   // One step of restoring division.
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign q_bit = (trial >= {1'b0, a_sr_ff});

   // Final forms of the finished results.
   assign prod    = {hi_ff, b_sr_ff};
   assign mul_mag = prod >> FRAC_BITS;
   assign add_ovf = (sign_a_ff == sign_b_ff) && (b_sr_ff[31] != sign_a_ff);

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      a_sr_in   = a_sr_ff;
      b_sr_in   = b_sr_ff;
      hi_in     = hi_ff;
      carry_in  = carry_ff;
      sign_a_in = sign_a_ff;
      sign_b_in = sign_b_ff;
      neg_in    = neg_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      done      = 1'b0;
      result    = 32'd0;

      case (state_ff)
         rpn_pkg::A_IDLE: begin
            if (ctl.start) begin
               op_in     = ctl.op;
               state_in  = rpn_pkg::A_RUN;
               sign_a_in = opa[31];
               hi_in     = 32'd0;
               rem_in    = 32'd0;
               carry_in  = 1'b0;
               case (ctl.op)
                  rpn_pkg::ALU_ADD: begin
                     a_sr_in   = opa;
                     b_sr_in   = opb;
                     sign_b_in = opb[31];
                     cnt_in    = CNTW'(32);
                  end
                  rpn_pkg::ALU_SUB: begin
                     a_sr_in   = opa;
                     b_sr_in   = ~opb;
                     carry_in  = 1'b1;
                     sign_b_in = ~opb[31];
                     cnt_in    = CNTW'(32);
                  end
                  rpn_pkg::ALU_MUL: begin
                     a_sr_in = mag_a;
                     b_sr_in = mag_b;
                     neg_in  = opa[31] ^ opb[31];
                     cnt_in  = CNTW'(32);
                  end
                  rpn_pkg::ALU_DIV: begin
                     a_sr_in = mag_b;
                     quo_in  = DW'(mag_a) << FRAC_BITS;
                     neg_in  = opa[31] ^ opb[31];
                     cnt_in  = CNTW'(DW);
                  end
                  default: begin
                     a_sr_in = mag_b;
                     quo_in  = DW'(mag_a);
                     neg_in  = opa[31];
                     cnt_in  = CNTW'(DW);
                  end
               endcase
            end
         end

         rpn_pkg::A_RUN: begin
            case (op_ff)
               rpn_pkg::ALU_ADD, rpn_pkg::ALU_SUB: begin
                  carry_in = (a_sr_ff[0] & b_sr_ff[0]) | (a_sr_ff[0] & carry_ff)
                           | (b_sr_ff[0] & carry_ff);
                  a_sr_in  = {1'b0, a_sr_ff[31:1]};
                  b_sr_in  = {sum_bit, b_sr_ff[31:1]};
               end
               rpn_pkg::ALU_MUL: begin
                  hi_in   = mul_sum[32:1];
                  b_sr_in = {mul_sum[0], b_sr_ff[31:1]};
               end
               default: begin
                  rem_in = q_bit ? 32'(trial - {1'b0, a_sr_ff}) : trial[31:0];
                  quo_in = {quo_ff[DW-2:0], q_bit};
               end
            endcase
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               state_in = rpn_pkg::A_FIN;
            end
         end

         rpn_pkg::A_FIN: begin
            done = 1'b1;
            case (op_ff)
               rpn_pkg::ALU_ADD, rpn_pkg::ALU_SUB: begin
                  if (add_ovf) begin
                     result = sign_a_ff ? rpn_pkg::SAT_MIN : rpn_pkg::SAT_MAX;
                  end else begin
                     result = b_sr_ff;
                  end
               end
               rpn_pkg::ALU_MUL: result = rpn_pkg::from_mag(mul_mag, neg_ff);
               rpn_pkg::ALU_DIV: result = rpn_pkg::from_mag(64'(quo_ff), neg_ff);
               default:          result = rpn_pkg::from_mag(64'(rem_ff), neg_ff);
            endcase
            state_in = rpn_pkg::A_IDLE;
         end

         default: begin
            state_in = rpn_pkg::A_IDLE;
         end
      endcase
   end

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpn_pkg::A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      a_sr_ff   <= a_sr_in;
      b_sr_ff   <= b_sr_in;
      hi_ff     <= hi_in;
      carry_ff  <= carry_in;
      sign_a_ff <= sign_a_in;
      sign_b_ff <= sign_b_in;
      neg_ff    <= neg_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
   end

endmodule

// ----- design/rpn_stack_calculator.sv -----
// Top level of the reverse Polish stack calculator on signed fixed-point words.
// Commands arrive as beats on the req_ channel (req_cmd, req_operand) and each
// command returns exactly one beat on the rsp_ channel (value, flag, status).
// A beat moves on a rising edge where valid is high and stall is low.
// One command is worked at a time; req_stall is high from acceptance until
// the result has been placed in the output register, and a new command may
// be taken while that result still waits to be collected.
// From acceptance each command goes through decode, then as it needs through the reads
// of the top and second words, the swap write-back or the serial unit, and last
// through the done state that loads the output register. Add, sub and mul wait on
// the serial unit that handles one bit per cycle over 32 steps, div and mod over
// 32 + FRAC_BITS steps; a missing operand or a zero divisor shortens the path.
// The next command can be accepted at the first edge where the rsp_ beat can move,
// so the block takes no new command before it is through with the last one.
// Reset empties the stack and drops any result not yet taken; stored words
// are not cleared. While rsp_stall is high the finished result holds on the
// rsp_ ports and the next command waits at the end of its work.
`include "rpn_stack_calculator_defines.svh"

module rpn_stack_calculator #(
   parameter int unsigned DEPTH     = 128,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_cmd,
   input  logic signed [31:0] req_operand,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic               rsp_value_valid,
   output logic [2:0]         rsp_status
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   rpn_pkg::ctl_state_type state_ff, state_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [3:0]    cmd_ff, cmd_in;
   logic [31:0]   opnd_ff, opnd_in;
   logic [31:0]   a_ff, a_in;
   logic [31:0]   b_ff, b_in;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   value_ff, value_in;
   logic          vvalid_ff, vvalid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic          rsp_vvalid_ff, rsp_vvalid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [31:0]   mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [31:0]   mem_rd_data;

   rpn_pkg::alu_ctl_type alu_ctl;
   logic                 alu_done;
   logic [31:0]          alu_result;

   logic [CW-1:0] depth_m1, depth_m2;
   logic [AW-1:0] top_addr, next_addr, push_addr;

   // Stack pointer arithmetic.
   assign depth_m1  = depth_ff - CW'(1);
   assign depth_m2  = depth_ff - CW'(2);
   assign top_addr  = depth_m1[AW-1:0];
   assign next_addr = depth_m2[AW-1:0];
   assign push_addr = depth_ff[AW-1:0];

   rpn_stack_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rpn_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .opa    (a_ff),
      .opb    (b_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   // Command sequencer: next state, stack accesses and result building.
   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      cmd_in        = cmd_ff;
      opnd_in       = opnd_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      status_in     = status_ff;
      value_in      = value_ff;
      vvalid_in     = vvalid_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_vvalid_in = rsp_vvalid_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = push_addr;
      mem_wr_data   = opnd_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = top_addr;
      alu_ctl       = '{start: 1'b0, op: rpn_pkg::ALU_ADD};

      case (state_ff)
         rpn_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               opnd_in   = req_operand;
               status_in = rpn_pkg::STAT_OK;
               value_in  = 32'd0;
               vvalid_in = 1'b0;
               state_in  = rpn_pkg::S_DECODE;
            end
         end

         rpn_pkg::S_DECODE: begin
            state_in = rpn_pkg::S_DONE;
            case (cmd_ff)
               rpn_pkg::CMD_PUSH: begin
                  if (depth_ff < CW'(DEPTH)) begin
                     mem_wr_en = 1'b1;
                     depth_in  = depth_ff + CW'(1);
                  end else begin
                     status_in = rpn_pkg::STAT_FULL;
                  end
               end
               rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL: begin
                  if (depth_ff == '0) begin
                     // Both pops miss; the zero result is still pushed.
                     a_in      = 32'd0;
                     b_in      = 32'd0;
                     status_in = rpn_pkg::STAT_EMPTY;
                     state_in  = rpn_pkg::S_EXEC;
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = rpn_pkg::S_READ_B;
                  end
               end
               rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD, rpn_pkg::CMD_PEEK: begin
                  if (depth_ff == '0) begin
                     status_in = rpn_pkg::STAT_EMPTY;
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = rpn_pkg::S_READ_B;
                  end
               end
               rpn_pkg::CMD_DUP: begin
                  if (depth_ff == '0) begin
                     status_in = rpn_pkg::STAT_EMPTY;
                  end else if (depth_ff >= CW'(DEPTH)) begin
                     status_in = rpn_pkg::STAT_FULL;
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = rpn_pkg::S_READ_B;
                  end
               end
               rpn_pkg::CMD_SWAP: begin
                  if (depth_ff > CW'(1)) begin
                     mem_rd_en = 1'b1;
                     state_in  = rpn_pkg::S_READ_B;
                  end else begin
                     status_in = rpn_pkg::STAT_SWAP;
                  end
               end
               rpn_pkg::CMD_CLEAR: begin
                  depth_in = '0;
               end
               rpn_pkg::CMD_RESULT: begin
                  vvalid_in = 1'b1;
                  if (depth_ff == '0) begin
                     status_in = rpn_pkg::STAT_EMPTY;
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = rpn_pkg::S_READ_B;
                  end
               end
               default: begin
                  status_in = rpn_pkg::STAT_UNKNOWN;
               end
            endcase
         end

         rpn_pkg::S_READ_B: begin
            // The top word is on the read port now.
            b_in     = mem_rd_data;
            state_in = rpn_pkg::S_DONE;
            case (cmd_ff)
               rpn_pkg::CMD_PEEK: begin
                  value_in  = mem_rd_data;
                  vvalid_in = 1'b1;
               end
               rpn_pkg::CMD_RESULT: begin
                  value_in = mem_rd_data;
                  depth_in = depth_m1;
               end
               rpn_pkg::CMD_DUP: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = mem_rd_data;
                  depth_in    = depth_ff + CW'(1);
               end
               rpn_pkg::CMD_SWAP: begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = next_addr;
                  state_in    = rpn_pkg::S_READ_A;
               end
               default: begin
                  // Arithmetic: the divisor or right operand is popped.
                  depth_in = depth_m1;
                  if (cmd_ff inside {rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD}
                      && mem_rd_data == 32'd0) begin
                     status_in = rpn_pkg::STAT_ZDIV;
                  end else if (depth_m1 != '0) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = next_addr;
                     state_in    = rpn_pkg::S_READ_A;
                  end else begin
                     a_in      = 32'd0;
                     status_in = rpn_pkg::STAT_EMPTY;
                     state_in  = rpn_pkg::S_EXEC;
                  end
               end
            endcase
         end

         rpn_pkg::S_READ_A: begin
            a_in = mem_rd_data;
            if (cmd_ff == rpn_pkg::CMD_SWAP) begin
               // Second word moves up to the top slot.
               mem_wr_en   = 1'b1;
               mem_wr_addr = top_addr;
               mem_wr_data = mem_rd_data;
               state_in    = rpn_pkg::S_SWAP_WR;
            end else begin
               depth_in = depth_m1;
               state_in = rpn_pkg::S_EXEC;
            end
         end

         rpn_pkg::S_SWAP_WR: begin
            // Old top word goes to the second slot.
            mem_wr_en   = 1'b1;
            mem_wr_addr = next_addr;
            mem_wr_data = b_ff;
            state_in    = rpn_pkg::S_DONE;
         end

         rpn_pkg::S_EXEC: begin
            alu_ctl.start = 1'b1;
            case (cmd_ff)
               rpn_pkg::CMD_ADD: alu_ctl.op = rpn_pkg::ALU_ADD;
               rpn_pkg::CMD_SUB: alu_ctl.op = rpn_pkg::ALU_SUB;
               rpn_pkg::CMD_MUL: alu_ctl.op = rpn_pkg::ALU_MUL;
               rpn_pkg::CMD_DIV: alu_ctl.op = rpn_pkg::ALU_DIV;
               default:          alu_ctl.op = rpn_pkg::ALU_MOD;
            endcase
            state_in = rpn_pkg::S_ALU_WAIT;
         end

         rpn_pkg::S_ALU_WAIT: begin
            if (alu_done) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = alu_result;
               depth_in    = depth_ff + CW'(1);
               state_in    = rpn_pkg::S_DONE;
            end
         end

         rpn_pkg::S_DONE: begin
            // Hand the beat to the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = value_ff;
               rsp_vvalid_in = vvalid_ff;
               rsp_status_in = status_ff;
               state_in      = rpn_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = rpn_pkg::S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpn_pkg::S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      opnd_ff       <= opnd_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      status_ff     <= status_in;
      value_ff      <= value_in;
      vvalid_ff     <= vvalid_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_vvalid_ff <= rsp_vvalid_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall       = (state_ff != rpn_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = $signed(rsp_value_ff);
   assign rsp_value_valid = rsp_vvalid_ff;
   assign rsp_status      = rsp_status_ff;

   // Checks on the sequencer and the stack pointer.
   `RPN_ASSERT(a_depth_bound, depth_ff <= CW'(DEPTH), "stack depth beyond capacity")
   `RPN_ASSERT(a_alu_done_wait, alu_done |-> state_ff == rpn_pkg::S_ALU_WAIT, "alu done unexpected")
   `RPN_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == rpn_pkg::S_DONE), "beat not from done")

endmodule

// ----- bench/rpn_stack_calculator_test.sv -----
// Self-checking testbench for the reverse Polish stack calculator.
`timescale 1ns / 100ps

module rpn_stack_calculator_test;

   localparam int unsigned STACK_DEPTH = 128;
   localparam int unsigned FRAC = 16;
   localparam logic [3:0]  CMD_UNKNOWN_MIN = rpn_pkg::CMD_RESULT + 4'd1;
   localparam logic [3:0]  CMD_UNKNOWN_MAX = 4'hF;
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          HOLD_CYCLES = 400;
   localparam int          DRAIN_CYCLES = 64;

   // One answer beat as seen on the rsp_ channel.
   typedef struct {
      logic [31:0] value;
      logic        has_value;
      logic [2:0]  status;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [3:0]         req_cmd = rpn_pkg::CMD_PUSH;
   logic signed [31:0] req_operand = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic               rsp_value_valid;
   logic [2:0]         rsp_status;

   // Shadow copy of the calculator stack.
   logic [31:0]  model_stack [0:STACK_DEPTH-1];
   int unsigned  model_depth = 0;

   answer_type   pending_answers [$];
   answer_type   got_answer;
   int           error_count = 0;
   int           cycle_count = 0;
   int           send_gap_pct = 36;
   int           rsp_stall_pct = 36;
   int           hold_req_seq = 0;
   int           hold_seen = 0;
   int           hold_left = 0;

   rpn_stack_calculator #(
      .DEPTH(STACK_DEPTH),
      .FRAC_BITS(FRAC)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_operand(req_operand),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_value_valid(rsp_value_valid),
      .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Saturates a wide signed sum or difference to a 32-bit word.
   function automatic logic [31:0] clamp_word(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return rpn_pkg::SAT_MAX;
      if (v < -64'sd2147483648) return rpn_pkg::SAT_MIN;
      return v[31:0];
   endfunction

   // Builds a saturated signed word from a magnitude and a sign.
   function automatic logic [31:0] signed_word(input logic [63:0] mag, input bit neg);
      if (neg) return (mag >= 64'h8000_0000) ? rpn_pkg::SAT_MIN : 32'd0 - mag[31:0];
      return (mag > 64'h7FFF_FFFF) ? rpn_pkg::SAT_MAX : mag[31:0];
   endfunction

   function automatic bit pop_word(output logic [31:0] w);
      if (model_depth > 0) begin
         model_depth--;
         w = model_stack[model_depth];
         return 1'b1;
      end
      w = '0;
      return 1'b0;
   endfunction

   function automatic bit push_word(input logic [31:0] w);
      if (model_depth < STACK_DEPTH) begin
         model_stack[model_depth] = w;
         model_depth++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Applies one command to the shadow stack and returns the answer beat it yields.
   function automatic answer_type apply_command(input logic [3:0] cmd,
                                                input logic [31:0] operand);
      answer_type         ans;
      logic [31:0]        a;
      logic [31:0]        b;
      logic [31:0]        r;
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      logic [63:0]        ma;
      logic [63:0]        mb;
      ans.value = '0;
      ans.has_value = 1'b0;
      ans.status = rpn_pkg::STAT_OK;
      case (cmd)
         rpn_pkg::CMD_PUSH: begin
            if (!push_word(operand)) ans.status = rpn_pkg::STAT_FULL;
         end
         rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL: begin
            // A missing operand reads as zero and the result is still pushed.
            if (!pop_word(b)) ans.status = rpn_pkg::STAT_EMPTY;
            if (!pop_word(a)) ans.status = rpn_pkg::STAT_EMPTY;
            sa = $signed(a);
            sb = $signed(b);
            ma = (sa < 0) ? -sa : sa;
            mb = (sb < 0) ? -sb : sb;
            if (cmd == rpn_pkg::CMD_ADD) r = clamp_word(sa + sb);
            else if (cmd == rpn_pkg::CMD_SUB) r = clamp_word(sa - sb);
            else r = signed_word((ma * mb) >> FRAC, (sa < 0) != (sb < 0));
            void'(push_word(r));
         end
         rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: begin
            // A zero divisor is consumed and the dividend stays on the stack.
            if (!pop_word(b)) begin
               ans.status = rpn_pkg::STAT_EMPTY;
            end else if (b == '0) begin
               ans.status = rpn_pkg::STAT_ZDIV;
            end else begin
               if (!pop_word(a)) ans.status = rpn_pkg::STAT_EMPTY;
               sa = $signed(a);
               sb = $signed(b);
               ma = (sa < 0) ? -sa : sa;
               mb = (sb < 0) ? -sb : sb;
               if (cmd == rpn_pkg::CMD_DIV)
                  r = signed_word((ma << FRAC) / mb, (sa < 0) != (sb < 0));
               else
                  r = signed_word(ma % mb, sa < 0);
               void'(push_word(r));
            end
         end
         rpn_pkg::CMD_PEEK: begin
            if (model_depth > 0) begin
               ans.value = model_stack[model_depth - 1];
               ans.has_value = 1'b1;
            end else begin
               ans.status = rpn_pkg::STAT_EMPTY;
            end
         end
         rpn_pkg::CMD_DUP: begin
            if (model_depth == 0) ans.status = rpn_pkg::STAT_EMPTY;
            else if (!push_word(model_stack[model_depth - 1])) ans.status = rpn_pkg::STAT_FULL;
         end
         rpn_pkg::CMD_SWAP: begin
            if (model_depth > 1) begin
               a = model_stack[model_depth - 1];
               model_stack[model_depth - 1] = model_stack[model_depth - 2];
               model_stack[model_depth - 2] = a;
            end else begin
               ans.status = rpn_pkg::STAT_SWAP;
            end
         end
         rpn_pkg::CMD_CLEAR: begin
            model_depth = 0;
         end
         rpn_pkg::CMD_RESULT: begin
            if (!pop_word(a)) ans.status = rpn_pkg::STAT_EMPTY;
            ans.value = a;
            ans.has_value = 1'b1;
         end
         default: begin
            ans.status = rpn_pkg::STAT_UNKNOWN;
         end
      endcase
      return ans;
   endfunction

   // Operand mix: extremes, zero divisors, small fixed-point numbers and raw noise.
   function automatic logic [31:0] random_operand();
      case ($urandom_range(7))
         0: return '0;
         1: return rpn_pkg::SAT_MAX;
         2: return rpn_pkg::SAT_MIN;
         3: return (int'($urandom_range(80)) - 40) * (1 << FRAC) + int'($urandom_range(16'hFFFF));
         4: return $urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Sends one command beat, with random idle cycles ahead of it, and records its answer.
   task automatic send_command(input logic [3:0] cmd, input logic [31:0] operand);
      answer_type ans;
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_operand <= operand;
      do @(posedge clock); while (req_stall);
      ans = apply_command(cmd, operand);
      pending_answers.push_back(ans);
   endtask

   // Mostly well-formed traffic: pushes dominate while the stack is shallow.
   task automatic send_random_command();
      logic [3:0] cmd;
      int         pick;
      pick = $urandom_range(99);
      if (pick < 3) cmd = 4'($urandom_range(CMD_UNKNOWN_MAX, CMD_UNKNOWN_MIN));
      else if (pick < 4) cmd = rpn_pkg::CMD_CLEAR;
      else if (pick < 35 || (model_depth < 2 && pick < 80)) cmd = rpn_pkg::CMD_PUSH;
      else cmd = 4'($urandom_range(rpn_pkg::CMD_RESULT, rpn_pkg::CMD_ADD));
      send_command(cmd, random_operand());
   endtask

   // Empty-stack cases, saturation, zero divisors and every command at least once.
   task automatic test_directed();
      send_command(rpn_pkg::CMD_PEEK, rpn_pkg::SAT_MAX);
      send_command(rpn_pkg::CMD_RESULT, '0);
      send_command(rpn_pkg::CMD_DUP, '0);
      send_command(rpn_pkg::CMD_SWAP, '0);
      send_command(rpn_pkg::CMD_ADD, '0);
      send_command(rpn_pkg::CMD_SWAP, '0);
      send_command(rpn_pkg::CMD_MOD, '0);
      send_command(rpn_pkg::CMD_DIV, '0);
      send_command(rpn_pkg::CMD_PUSH, 32'h0003_0000);
      send_command(rpn_pkg::CMD_DIV, '0);
      send_command(rpn_pkg::CMD_PUSH, rpn_pkg::SAT_MAX);
      send_command(rpn_pkg::CMD_DUP, '0);
      send_command(rpn_pkg::CMD_ADD, '0);
      send_command(rpn_pkg::CMD_PUSH, rpn_pkg::SAT_MIN);
      send_command(rpn_pkg::CMD_MUL, '0);
      send_command(rpn_pkg::CMD_PUSH, 32'h0000_0001);
      send_command(rpn_pkg::CMD_DIV, '0);
      send_command(rpn_pkg::CMD_PUSH, 32'hFFF8_8000);
      send_command(rpn_pkg::CMD_PUSH, 32'h0002_0000);
      send_command(rpn_pkg::CMD_MOD, '0);
      send_command(rpn_pkg::CMD_SWAP, '0);
      send_command(rpn_pkg::CMD_SUB, '0);
      send_command(rpn_pkg::CMD_PEEK, '0);
      send_command(CMD_UNKNOWN_MAX, 32'hFFFF_FFFF);
      send_command(rpn_pkg::CMD_CLEAR, '0);
   endtask

   // Fills the stack, pushes and duplicates onto the full stack, then peeks, swaps, multiplies, pops and clears.
   task automatic test_full_stack();
      for (int n = 0; n < STACK_DEPTH; n++) send_command(rpn_pkg::CMD_PUSH, random_operand());
      send_command(rpn_pkg::CMD_PUSH, random_operand());
      send_command(rpn_pkg::CMD_DUP, '0);
      send_command(rpn_pkg::CMD_PEEK, '0);
      send_command(rpn_pkg::CMD_SWAP, '0);
      send_command(rpn_pkg::CMD_MUL, '0);
      send_command(rpn_pkg::CMD_RESULT, '0);
      send_command(rpn_pkg::CMD_CLEAR, '0);
   endtask

   task automatic test_random_traffic(input int count);
      send_gap_pct = 36;
      rsp_stall_pct = 36;
      repeat (count) send_random_command();
   endtask

   // Back-to-back beats on both channels.
   task automatic test_no_idle(input int count);
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      repeat (count) send_random_command();
      send_gap_pct = 36;
      rsp_stall_pct = 36;
   endtask

   // The receiver holds off for a long stretch while commands keep coming.
   task automatic test_backpressure(input int count);
      send_gap_pct = 0;
      hold_req_seq++;
      repeat (count) send_random_command();
      send_gap_pct = 36;
   endtask

   // Receiver side: random stalls, or a counted hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_seen != hold_req_seq) begin
         hold_seen = hold_req_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Compares each answer beat with the oldest pending answer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("answer beat with none pending: value %h flag %b status %0d",
                   rsp_value, rsp_value_valid, rsp_status);
            error_count++;
         end else begin
            got_answer = pending_answers.pop_front();
            if (rsp_value !== got_answer.value) begin
               $error("rsp_value: expected %h, actual %h", got_answer.value, rsp_value);
               error_count++;
            end
            if (rsp_value_valid !== got_answer.has_value) begin
               $error("rsp_value_valid: expected %b, actual %b",
                      got_answer.has_value, rsp_value_valid);
               error_count++;
            end
            if (rsp_status !== got_answer.status) begin
               $error("rsp_status: expected %0d, actual %0d", got_answer.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_stack();
      test_random_traffic(1300);
      test_no_idle(300);
      test_backpressure(40);
      test_random_traffic(150);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
